// ----- rtl/udc_pkg.sv -----
// Shared types, codes and calendar helper functions for the Unix date converter.
`default_nettype none
package udc_pkg;

    // command codes
    localparam logic [1:0] CMD_SPLIT  = 2'd0;
    localparam logic [1:0] CMD_PACK   = 2'd1;
    localparam logic [1:0] CMD_FUTURE = 2'd2;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] unix_time;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [7:0]  add_years;
        logic [7:0]  add_months;
        logic [31:0] add_days;
        logic [31:0] add_seconds;
    } cmd_t;

    typedef struct packed {
        logic [31:0] result_seconds;
        logic [11:0] result_year;
        logic [3:0]  result_month;
        logic [4:0]  result_day;
        logic [4:0]  result_hour;
        logic [5:0]  result_minute;
        logic [5:0]  result_second;
    } rsp_t;

    // calendar fields of one split timestamp
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_t;

    // operands of the packing pipeline
    typedef struct packed {
        logic [12:0] year;
        logic [8:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [7:0]  add_years;
        logic        use_adds;
        logic [31:0] add_days;
        logic [31:0] add_seconds;
    } pack_in_t;

    // x / 25 for x up to 1024, by reciprocal multiplication
    function automatic logic [6:0] div25(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd1311;
        return p[21:15];
    endfunction

    // days before the first of month m (1 based) in a common year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // days from the epoch to 1 January of year 1970 + k, k up to 137
    function automatic logic [16:0] epoch_days(input logic [7:0] k);
        logic [8:0] k1;
        k1 = {1'b0, k} + 9'd1;
        return 17'(17'(k) * 17'd365) + 17'(k1[8:2]) - ((k >= 8'd131) ? 17'd1 : 17'd0);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/udc_split.sv -----
// Five-stage pipeline splitting Unix seconds into calendar date and time of day.
`default_nettype none
module udc_split #(
    parameter int SideW = 34
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [31:0]        t,
    input  wire logic [SideW-1:0]   side_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output udc_pkg::date_t          date,
    output logic [SideW-1:0]        side_out
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // stage enables: a stage moves when empty or when its successor moves
    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // stage 1: whole days, t / 86400 as (t >> 7) / 675
    logic [50:0]      q_prod;
    logic [15:0]      q1_next;
    logic [31:0]      t1_reg;
    logic [15:0]      q1_reg;
    logic [SideW-1:0] s1_reg;

    assign q_prod  = 51'(t[31:7]) * 51'd50903317;
    assign q1_next = q_prod[50:35];

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            t1_reg <= t;
            q1_reg <= q1_next;
            s1_reg <= side_in;
        end
    end

    // stage 2: seconds of day and a first year estimate
    logic [31:0]      day_secs;
    logic [27:0]      k_prod;
    logic [16:0]      rem2_next;
    logic [16:0]      rem2_reg;
    logic [15:0]      days2_reg;
    logic [7:0]       k2_reg;
    logic [SideW-1:0] s2_reg;

    assign day_secs  = 32'(q1_reg) * 32'd86400;
    assign rem2_next = 17'(t1_reg - day_secs);
    assign k_prod    = 28'(q1_reg) * 28'd2870;

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            rem2_reg  <= rem2_next;
            days2_reg <= q1_reg;
            k2_reg    <= k_prod[27:20];
            s2_reg    <= s1_reg;
        end
    end

    // stage 3: correct the year by one either way, hour of day
    logic [16:0]      d_lo, d_mid, d_hi, d_base;
    logic [7:0]       k3_next;
    logic [25:0]      h_prod;
    logic [7:0]       k3_reg;
    logic [8:0]       yday3_reg;
    logic [4:0]       h3_reg;
    logic [16:0]      rem3_reg;
    logic [SideW-1:0] s3_reg;

    assign d_lo   = udc_pkg::epoch_days(k2_reg - 8'd1);
    assign d_mid  = udc_pkg::epoch_days(k2_reg);
    assign d_hi   = udc_pkg::epoch_days(k2_reg + 8'd1);
    assign h_prod = 26'(rem2_reg[16:4]) * 26'd4661;

    always_comb
    begin
        priority if ({1'b0, days2_reg} < d_mid)
        begin
            k3_next = k2_reg - 8'd1;
            d_base  = d_lo;
        end
        else if ({1'b0, days2_reg} >= d_hi)
        begin
            k3_next = k2_reg + 8'd1;
            d_base  = d_hi;
        end
        else
        begin
            k3_next = k2_reg;
            d_base  = d_mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            k3_reg    <= k3_next;
            yday3_reg <= 9'({1'b0, days2_reg} - d_base);
            h3_reg    <= h_prod[24:20];
            rem3_reg  <= rem2_reg;
            s3_reg    <= s2_reg;
        end
    end

    // stage 4: month and day from day of year, seconds within the hour
    logic [11:0]      y4_next;
    logic             leap4;
    logic [3:0]       cnt;
    logic [3:0]       mo4_next;
    logic [8:0]       mst;
    logic [11:0]      y4_reg;
    logic [3:0]       mo4_reg;
    logic [4:0]       d4_reg;
    logic [4:0]       h4_reg;
    logic [11:0]      rh4_reg;
    logic [SideW-1:0] s4_reg;

    assign y4_next = udc_pkg::EPOCH_YEAR + 12'(k3_reg);
    assign leap4   = (y4_next[1:0] == 2'd0) && (y4_next != 12'd2100);

    always_comb
    begin
        cnt = 4'd0;
        for (int j = 2; j <= 12; j++)
        begin
            if (yday3_reg >= udc_pkg::month_start(4'(j)) + ((j >= 3 && leap4) ? 9'd1 : 9'd0))
                cnt = cnt + 4'd1;
        end
        mo4_next = cnt + 4'd1;
        mst = udc_pkg::month_start(mo4_next)
            + ((mo4_next >= 4'd3 && leap4) ? 9'd1 : 9'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            y4_reg  <= y4_next;
            mo4_reg <= mo4_next;
            d4_reg  <= 5'(yday3_reg - mst + 9'd1);
            h4_reg  <= h3_reg;
            rh4_reg <= 12'(rem3_reg - 17'(17'(h3_reg) * 17'd3600));
            s4_reg  <= s3_reg;
        end
    end

    // stage 5: minute and second
    logic [20:0]      m_prod;
    logic [5:0]       min5_next;
    udc_pkg::date_t   date_reg;
    logic [SideW-1:0] s5_reg;

    assign m_prod    = 21'(rh4_reg[11:2]) * 21'd1093;
    assign min5_next = m_prod[19:14];

    always_ff @(posedge clk)
    begin
        if (en5 && v4_reg)
        begin
            date_reg.year   <= y4_reg;
            date_reg.month  <= mo4_reg;
            date_reg.day    <= d4_reg;
            date_reg.hour   <= h4_reg;
            date_reg.minute <= min5_next;
            date_reg.second <= 6'(rh4_reg - 12'(12'(min5_next) * 12'd60));
            s5_reg          <= s4_reg;
        end
    end

    assign date     = date_reg;
    assign side_out = s5_reg;

endmodule
`default_nettype wire

// ----- rtl/udc_pack.sv -----
// Four-stage pipeline packing calendar fields into Unix seconds, plus an optional offset.
`default_nettype none
module udc_pack #(
    parameter int SideW = 34
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  udc_pkg::pack_in_t       op,
    input  wire logic [SideW-1:0]   side_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             t,
    output logic [SideW-1:0]        side_out
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: carry surplus months into years, then add the year offset
    logic [8:0]        mm;
    logic [20:0]       cy_prod;
    logic [5:0]        cy;
    logic [3:0]        mo1_next;
    logic [12:0]       y1_next;
    udc_pkg::pack_in_t op1_next;
    udc_pkg::pack_in_t op1_reg;
    logic [SideW-1:0]  s1_reg;

    assign mm      = op.month - 9'd1;
    assign cy_prod = 21'(mm) * 21'd2731;
    assign cy      = cy_prod[20:15];

    always_comb
    begin
        if (op.month > 9'd12)
        begin
            mo1_next = 4'(mm - 9'(9'(cy) * 9'd12) + 9'd1);
            y1_next  = op.year + 13'(cy) + 13'(op.add_years);
        end
        else
        begin
            mo1_next = op.month[3:0];
            y1_next  = op.year + 13'(op.add_years);
        end
    end

    always_comb
    begin
        op1_next       = op;
        op1_next.year  = y1_next;
        op1_next.month = {5'd0, mo1_next};
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            op1_reg <= op1_next;
            s1_reg  <= side_in;
        end
    end

    // stage 2: leap count and days before the year, month offset, day offset product
    logic [12:0]      ya;
    logic [10:0]      lsum;
    logic [10:0]      y4, y16;
    logic             leap2;
    logic [21:0]      dby2_next;
    logic [21:0]      dby2_reg;
    logic [8:0]       mst2_reg;
    logic [31:0]      ad2_reg;
    udc_pkg::pack_in_t op2_reg;
    logic [SideW-1:0] s2_reg;

    assign ya   = op1_reg.year - 13'd1;
    assign lsum = ya[12:2] - 11'(udc_pkg::div25(ya[12:2]))
                + 11'(udc_pkg::div25(11'(ya[12:4])));
    assign y4   = op1_reg.year[12:2];
    assign y16  = 11'(op1_reg.year[12:4]);
    assign leap2 = (op1_reg.year[1:0] == 2'd0)
                && ((y4 != 11'(udc_pkg::div25(y4)) * 11'd25)
                    || ((op1_reg.year[3:0] == 4'd0)
                        && (y16 == 11'(udc_pkg::div25(y16)) * 11'd25)));
    assign dby2_next = (op1_reg.year > 13'(udc_pkg::EPOCH_YEAR))
        ? 22'(22'(op1_reg.year - 13'(udc_pkg::EPOCH_YEAR)) * 22'd365)
          + 22'(lsum) - 22'd477
        : 22'd0;

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            dby2_reg <= dby2_next;
            mst2_reg <= udc_pkg::month_start(op1_reg.month[3:0])
                      + ((op1_reg.month[3:0] > 4'd2 && leap2) ? 9'd1 : 9'd0);
            ad2_reg  <= op1_reg.add_days * 32'd86400;
            op2_reg  <= op1_reg;
            s2_reg   <= s1_reg;
        end
    end

    // stage 3: day count, seconds of day, total offset
    logic [31:0]      days3_reg;
    logic [17:0]      hms3_reg;
    logic [31:0]      extra3_reg;
    logic [SideW-1:0] s3_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            days3_reg  <= 32'(dby2_reg) + 32'(mst2_reg) + 32'(op2_reg.day) - 32'd1;
            hms3_reg   <= 18'(18'(op2_reg.hour) * 18'd3600)
                        + 18'(18'(op2_reg.minute) * 18'd60) + 18'(op2_reg.second);
            extra3_reg <= op2_reg.use_adds ? ad2_reg + op2_reg.add_seconds : 32'd0;
            s3_reg     <= s2_reg;
        end
    end

    // stage 4: seconds, wrapping modulo 2^32
    logic [31:0]      t4_reg;
    logic [SideW-1:0] s4_reg;

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            t4_reg <= days3_reg * 32'd86400 + 32'(hms3_reg) + extra3_reg;
            s4_reg <= s3_reg;
        end
    end

    assign t        = t4_reg;
    assign side_out = s4_reg;

endmodule
`default_nettype wire

// ----- rtl/unix_calendar_date_converter_top.sv -----
// Top level of the Unix seconds / Gregorian calendar converter.
`default_nettype none
// Converts between 32-bit Unix seconds and Gregorian date and time. Command
// split turns unix_time into date fields, command pack turns date fields into
// seconds, command future splits unix_time, adds months, years, days and
// seconds and splits the sum again. The block takes one transfer per clock
// while cmd_ready is high and returns each result in order: a five-stage split
// pipeline, a four-stage pack pipeline and a second five-stage split pipeline
// in series, every command passing all three. Each stage holds its item only
// while the stage after it is full, so empty stages fill behind a stalled
// output. Unused result fields are zero; an unused command gives all zeros.
module unix_calendar_date_converter_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  udc_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output udc_pkg::rsp_t  rsp
);

    localparam int CmdW  = $bits(udc_pkg::cmd_t);
    localparam int TailW = 34;

    // first split: the incoming timestamp
    logic              a_valid, a_ready;
    udc_pkg::date_t    a_date;
    logic [CmdW-1:0]   a_side;
    udc_pkg::cmd_t     a_cmd;

    udc_split #(.SideW(CmdW)) u_split_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_valid),
        .in_ready  (cmd_ready),
        .t         (cmd.unix_time),
        .side_in   (CmdW'(cmd)),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .date      (a_date),
        .side_out  (a_side)
    );

    assign a_cmd = a_side;

    // pack operands: split result for the future date, else the given fields
    udc_pkg::pack_in_t p_op;
    logic [TailW-1:0]  p_side_in;

    always_comb
    begin
        p_op.add_days    = a_cmd.add_days;
        p_op.add_seconds = a_cmd.add_seconds;
        if (a_cmd.command == udc_pkg::CMD_FUTURE)
        begin
            p_op.year      = {1'b0, a_date.year};
            p_op.month     = 9'(a_date.month) + 9'(a_cmd.add_months);
            p_op.day       = a_date.day;
            p_op.hour      = a_date.hour;
            p_op.minute    = a_date.minute;
            p_op.second    = a_date.second;
            p_op.add_years = a_cmd.add_years;
            p_op.use_adds  = 1'b1;
        end
        else
        begin
            p_op.year      = {1'b0, a_cmd.year};
            p_op.month     = 9'(a_cmd.month);
            p_op.day       = a_cmd.day;
            p_op.hour      = a_cmd.hour;
            p_op.minute    = a_cmd.minute;
            p_op.second    = a_cmd.second;
            p_op.add_years = 8'd0;
            p_op.use_adds  = 1'b0;
        end
    end

    assign p_side_in = {a_cmd.command, a_cmd.unix_time};

    logic              p_valid, p_ready;
    logic [31:0]       p_t;
    logic [TailW-1:0]  p_side;

    udc_pack #(.SideW(TailW)) u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .op        (p_op),
        .side_in   (p_side_in),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .t         (p_t),
        .side_out  (p_side)
    );

    // second split: the original timestamp for a plain split, else the packed sum
    logic [31:0]       b_t;
    logic              b_valid;
    udc_pkg::date_t    b_date;
    logic [TailW-1:0]  b_side;

    assign b_t = (p_side[33:32] == udc_pkg::CMD_SPLIT) ? p_side[31:0] : p_t;

    udc_split #(.SideW(TailW)) u_split_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .t         (b_t),
        .side_in   ({p_side[33:32], p_t}),
        .out_valid (b_valid),
        .out_ready (rsp_ready),
        .date      (b_date),
        .side_out  (b_side)
    );

    // result formatting by command
    always_comb
    begin
        rsp = '0;
        unique case (b_side[33:32])
            udc_pkg::CMD_SPLIT, udc_pkg::CMD_FUTURE:
            begin
                rsp.result_year   = b_date.year;
                rsp.result_month  = b_date.month;
                rsp.result_day    = b_date.day;
                rsp.result_hour   = b_date.hour;
                rsp.result_minute = b_date.minute;
                rsp.result_second = b_date.second;
            end
            udc_pkg::CMD_PACK:
                rsp.result_seconds = b_side[31:0];
            default:
                rsp = '0;
        endcase
    end

    assign rsp_valid = b_valid;

    // input is held back only when every stage is full and the output is stalled
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (rsp_valid && !rsp_ready))
        else $error("input stalled while the pipeline can move");

    // a produced date has a month in range, a nonzero day and a zero seconds result
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.result_year != 12'd0) |->
            (rsp.result_month >= 4'd1 && rsp.result_month <= 4'd12
             && rsp.result_day != 5'd0 && rsp.result_seconds == 32'd0))
        else $error("date result out of range");

    // time of day stays in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.result_hour < 5'd24 && rsp.result_minute < 6'd60
                       && rsp.result_second < 6'd60))
        else $error("time of day out of range");

endmodule
`default_nettype wire
